// ===== design/bdq_pkg.sv =====
`default_nettype none

package bdq_pkg;

  localparam int DataW   = 32;
  localparam int CountW  = 11;
  localparam int FuncW   = 3;
  localparam int StatusW = 2;

  typedef enum logic [FuncW-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_STATUS     = 3'd5
  } bdq_op_t;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bdq_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESULT,
    S_HOLD
  } bdq_state_t;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic signed [DataW-1:0] push_value;
  } bdq_cmd_t;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] popped_value;
    logic [CountW-1:0]       entry_count;
    logic signed [DataW-1:0] first_value;
    logic signed [DataW-1:0] last_value;
    logic                    is_empty;
  } bdq_rsp_t;

endpackage

`default_nettype wire

// ===== design/bounded_deque_unit.sv =====
`default_nettype none

// Channel | Direction | Handshake            | Payload
// cmd     | in        | cmd_valid, cmd_stall | bdq_cmd_t (func, push_value)
// rsp     | out       | rsp_valid, rsp_stall | bdq_rsp_t (status, popped, count, first, last)
//
// In the accept cycle of a transaction the indices update, a push is written into the slot
// RAM or the neighbor read of a pop starts; the next cycle takes the RAM read data into the
// front/back cache and, unless the output stalls, into the result register.
// Reset clears head, tail, count and the handshake state; slot contents are not cleared.
// A stalled result is held in the output register while the next transaction is
// accepted; that transaction then waits in the hold state until the register frees.

module bounded_deque_unit #(
  parameter int CAPACITY = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  wire bdq_pkg::bdq_cmd_t cmd,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output bdq_pkg::bdq_rsp_t      rsp
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX   = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);
  localparam logic [CW-1:0] TWO_COUNT  = CW'(2);

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  bdq_pkg::bdq_state_t state, state_next;

  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [bdq_pkg::DataW-1:0] first, first_next;
  logic [bdq_pkg::DataW-1:0] last, last_next;
  logic fetch, fetch_next;
  logic fetch_front, fetch_front_next;
  bdq_pkg::bdq_status_t req_status, req_status_next;
  logic [bdq_pkg::DataW-1:0] req_popped, req_popped_next;

  logic accept;
  logic is_full;
  logic was_empty;
  logic rsp_load;
  logic [bdq_pkg::DataW-1:0] cur_first;
  logic [bdq_pkg::DataW-1:0] cur_last;
  bdq_pkg::bdq_rsp_t rsp_next;

  logic                      wr_en;
  logic [IW-1:0]             wr_addr;
  logic [bdq_pkg::DataW-1:0] wr_data;
  logic                      rd_en;
  logic [IW-1:0]             rd_addr;
  logic [bdq_pkg::DataW-1:0] rd_data;

  bdq_ram #(
    .WIDTH(bdq_pkg::DataW),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign cmd_stall = (state != bdq_pkg::S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign is_full   = (count == FULL_COUNT);
  assign was_empty = (count == '0);

  // Fold in the neighbor slot that a pop fetched.
  assign cur_first = (fetch && fetch_front) ? rd_data : first;
  assign cur_last  = (fetch && !fetch_front) ? rd_data : last;

  assign rsp_load = (state == bdq_pkg::S_RESULT || state == bdq_pkg::S_HOLD) &&
                    (!rsp_valid || !rsp_stall);

  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    first_next       = first;
    last_next        = last;
    fetch_next       = fetch;
    fetch_front_next = fetch_front;
    req_status_next  = req_status;
    req_popped_next  = req_popped;
    wr_en            = 1'b0;
    wr_addr          = tail;
    wr_data          = cmd.push_value;
    rd_en            = 1'b0;
    rd_addr          = idx_next(head);

    case (state)
      bdq_pkg::S_IDLE: begin
        if (accept) begin
          state_next      = bdq_pkg::S_RESULT;
          req_status_next = bdq_pkg::ST_DONE;
          req_popped_next = '0;
          fetch_next      = 1'b0;
          case (bdq_pkg::bdq_op_t'(cmd.func))
            bdq_pkg::OP_PUSH_BACK: begin
              if (is_full) begin
                req_status_next = bdq_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = tail;
                tail_next  = idx_next(tail);
                count_next = count + 1'b1;
                last_next  = cmd.push_value;
                if (was_empty) begin
                  first_next = cmd.push_value;
                end
              end
            end
            bdq_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                req_status_next = bdq_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = idx_prev(head);
                head_next  = idx_prev(head);
                count_next = count + 1'b1;
                first_next = cmd.push_value;
                if (was_empty) begin
                  last_next = cmd.push_value;
                end
              end
            end
            bdq_pkg::OP_POP_BACK: begin
              if (was_empty) begin
                req_status_next = bdq_pkg::ST_EMPTY;
              end else begin
                req_popped_next = last;
                tail_next       = idx_prev(tail);
                count_next      = count - 1'b1;
                if (count == TWO_COUNT) begin
                  last_next = first;
                end else if (count > TWO_COUNT) begin
                  // New back sits two slots behind the old tail.
                  rd_en            = 1'b1;
                  rd_addr          = idx_prev(idx_prev(tail));
                  fetch_next       = 1'b1;
                  fetch_front_next = 1'b0;
                end
              end
            end
            bdq_pkg::OP_POP_FRONT: begin
              if (was_empty) begin
                req_status_next = bdq_pkg::ST_EMPTY;
              end else begin
                req_popped_next = first;
                head_next       = idx_next(head);
                count_next      = count - 1'b1;
                if (count == TWO_COUNT) begin
                  first_next = last;
                end else if (count > TWO_COUNT) begin
                  rd_en            = 1'b1;
                  rd_addr          = idx_next(head);
                  fetch_next       = 1'b1;
                  fetch_front_next = 1'b1;
                end
              end
            end
            bdq_pkg::OP_CLEAR: begin
              head_next  = '0;
              tail_next  = '0;
              count_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      bdq_pkg::S_RESULT: begin
        first_next = cur_first;
        last_next  = cur_last;
        fetch_next = 1'b0;
        state_next = rsp_load ? bdq_pkg::S_IDLE : bdq_pkg::S_HOLD;
      end
      bdq_pkg::S_HOLD: begin
        if (rsp_load) begin
          state_next = bdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = bdq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_next.status       = req_status;
    rsp_next.popped_value = req_popped;
    rsp_next.entry_count  = bdq_pkg::CountW'(count);
    rsp_next.first_value  = was_empty ? '0 : cur_first;
    rsp_next.last_value   = was_empty ? '0 : cur_last;
    rsp_next.is_empty     = was_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bdq_pkg::S_IDLE;
      head        <= '0;
      tail        <= '0;
      count       <= '0;
      fetch       <= 1'b0;
      fetch_front <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      head        <= head_next;
      tail        <= tail_next;
      count       <= count_next;
      fetch       <= fetch_next;
      fetch_front <= fetch_front_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    first      <= first_next;
    last       <= last_next;
    req_status <= req_status_next;
    req_popped <= req_popped_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count exceeds capacity");

  a_ring_ends: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == FULL_COUNT) |-> head == tail)
    else $error("head and tail disagree at an empty or full ring");

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == bdq_pkg::S_RESULT && cmd_stall)
    else $error("accepted transaction did not enter the result cycle");

  a_fetch_issued: assert property (@(posedge clk) disable iff (rst)
    fetch |-> state == bdq_pkg::S_RESULT && $past(rd_en))
    else $error("neighbor fetch pending without a RAM read");

endmodule

`default_nettype wire

// ===== design/bdq_ram.sv =====
`default_nettype none

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   wr_en,
  input  wire logic [AddrW-1:0]       wr_addr,
  input  wire logic [WIDTH-1:0]       wr_data,
  input  wire logic                   rd_en,
  input  wire logic [AddrW-1:0]       rd_addr,
  output logic      [WIDTH-1:0]       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
